// ===== hw/rtl/mcsw_pkg.sv =====
`default_nettype none

package mcsw_pkg;

    localparam int WORD_BITS = 64;
    localparam int WORD_LOG  = $clog2(WORD_BITS);
    localparam int MAX_WORDS = 64;
    localparam int IDX_W     = $clog2(MAX_WORDS + 1);
    localparam int SHIFT_W   = 32;
    localparam int QUOT_W    = SHIFT_W - WORD_LOG;
    localparam int QX_W      = (QUOT_W > IDX_W ? QUOT_W : IDX_W) + 1;

    localparam logic signed [1:0] ORDER_LESS    = -2'sd1;
    localparam logic signed [1:0] ORDER_EQUAL   = 2'sd0;
    localparam logic signed [1:0] ORDER_GREATER = 2'sd1;

    typedef struct packed {
        logic                 high_nz;
        logic                 low_nz;
        logic [WORD_BITS-1:0] word_q;
        logic [WORD_BITS-1:0] word_q1;
    } mcsw_track_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcsw_compare.sv =====
`default_nettype none

module mcsw_compare (
    input  var mcsw_pkg::mcsw_track_t              track,
    input  var logic [mcsw_pkg::WORD_BITS-1:0]     multiplier,
    input  var logic [mcsw_pkg::WORD_LOG-1:0]      shift_low,
    output logic signed [1:0]                      order
);
    import mcsw_pkg::*;

    localparam logic [WORD_LOG:0] WORD_BITS_C = (WORD_LOG + 1)'(WORD_BITS);

    logic [WORD_BITS-1:0] b0;
    logic [WORD_BITS-1:0] b1;
    logic [WORD_LOG:0]    rsh;

    always_comb begin
        rsh = WORD_BITS_C - {1'b0, shift_low};
        b0  = multiplier << shift_low;
        if (shift_low == '0) begin
            b1 = '0;
        end else begin
            b1 = multiplier >> rsh;
        end

        if (track.high_nz) begin
            order = ORDER_GREATER;
        end else if (track.word_q1 != b1) begin
            order = (track.word_q1 > b1) ? ORDER_GREATER : ORDER_LESS;
        end else if (track.word_q != b0) begin
            order = (track.word_q > b0) ? ORDER_GREATER : ORDER_LESS;
        end else begin
            order = track.low_nz ? ORDER_GREATER : ORDER_EQUAL;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/multiword_compare_shifted_word_unit.sv =====
// Compares an unsigned multiword number A against B * 2^E.
// Input channel (s_): one 64-bit word of A per transaction, least significant
// word first; s_last_word marks the final word. s_multiplier (B) and
// s_shift_amount (E) are sampled with the first word of each number only.
// Result channel (m_): one transaction per number, carrying m_order:
// -1 when A < B*2^E, 0 when equal, +1 when greater.
// Throughput: one word per cycle, no gaps between numbers, unless a final word stalls.
// The last word is held in the input register and then, once the result
// register is free or being taken, classified into the result register,
// which raises m_valid; all words before the last give no result.
// The word counter saturates at 64; longer numbers keep being classified as
// if every further word sat at index 64.
// Reset (aresetn low, synchronous) empties both registers and starts a new
// number. When the receiver stalls, the result register holds; non-final
// words keep flowing, and a final word waits in the input register, which
// then stalls the input channel until the result is taken.
`default_nettype none

module multiword_compare_shifted_word_unit (
    input  var logic                                  aclk,
    input  var logic                                  aresetn,
    input  var logic                                  s_valid,
    output logic                                      s_ready,
    input  var logic [mcsw_pkg::WORD_BITS-1:0]        s_number_word,
    input  var logic                                  s_last_word,
    input  var logic [mcsw_pkg::WORD_BITS-1:0]        s_multiplier,
    input  var logic [mcsw_pkg::SHIFT_W-1:0]          s_shift_amount,
    output logic                                      m_valid,
    input  var logic                                  m_ready,
    output logic signed [1:0]                         m_order
);
    import mcsw_pkg::*;

    logic                 in_valid_reg;
    logic [WORD_BITS-1:0] in_word_reg;
    logic                 in_last_reg;
    logic [WORD_BITS-1:0] in_mult_reg;
    logic [SHIFT_W-1:0]   in_shift_reg;

    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [WORD_BITS-1:0] mult_reg;
    logic [SHIFT_W-1:0]   shift_reg;
    mcsw_track_t          track_reg, track_next;

    logic                 out_valid_reg;
    logic signed [1:0]    out_order_reg;

    logic                 in_advance;
    logic                 first;
    logic [WORD_BITS-1:0] cur_mult;
    logic [SHIFT_W-1:0]   cur_shift;
    logic [QX_W-1:0]      idx_ext;
    logic [QX_W-1:0]      q_ext;
    logic                 nz;
    logic signed [1:0]    cmp_order;

    assign in_advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || in_advance;
    assign m_valid    = out_valid_reg;
    assign m_order    = out_order_reg;

    always_comb begin
        first     = (idx_reg == '0);
        cur_mult  = first ? in_mult_reg : mult_reg;
        cur_shift = first ? in_shift_reg : shift_reg;
        track_next = first ? '0 : track_reg;
        idx_ext   = QX_W'(idx_reg);
        q_ext     = QX_W'(cur_shift[SHIFT_W-1:WORD_LOG]);
        nz        = (in_word_reg != '0);

        if (idx_ext < q_ext) begin
            track_next.low_nz = track_next.low_nz | nz;
        end else if (idx_ext == q_ext) begin
            track_next.word_q = in_word_reg;
        end else if (idx_ext == q_ext + QX_W'(1)) begin
            track_next.word_q1 = in_word_reg;
        end else begin
            track_next.high_nz = track_next.high_nz | nz;
        end

        if (in_last_reg) begin
            idx_next = '0;
        end else if (idx_reg < IDX_W'(MAX_WORDS)) begin
            idx_next = idx_reg + IDX_W'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    mcsw_compare u_compare (
        .track      (track_next),
        .multiplier (cur_mult),
        .shift_low  (cur_shift[WORD_LOG-1:0]),
        .order      (cmp_order)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready) begin
            in_word_reg  <= s_number_word;
            in_last_reg  <= s_last_word;
            in_mult_reg  <= s_multiplier;
            in_shift_reg <= s_shift_amount;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            track_reg <= '0;
        end else if (in_advance) begin
            idx_reg   <= idx_next;
            track_reg <= track_next;
        end
        if (in_advance) begin
            mult_reg  <= cur_mult;
            shift_reg <= cur_shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (in_advance && in_last_reg) begin
            out_order_reg <= cmp_order;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mcsw_checker.sv =====
`default_nettype none

module mcsw_checker (
    input  var logic                           aclk,
    input  var logic                           aresetn,
    input  var logic                           s_valid,
    input  var logic                           s_ready,
    input  var logic                           s_last_word,
    input  var logic                           m_valid,
    input  var logic                           m_ready,
    input  var logic signed [1:0]              m_order
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_order))
        else $error("stalled result changed");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_order != 2'sb10)
        else $error("result code out of range");

    // a new result follows an accepted final word
    a_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last_word, 2))
        else $error("result without a final word");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

bind multiword_compare_shifted_word_unit mcsw_checker u_mcsw_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_last_word (s_last_word),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_order     (m_order)
);

`default_nettype wire
